[rtl/mceb_pkg.sv]
package mceb_pkg;

    // Bits available in one bitmap row; pixel 0 sits in the top bit.
    localparam int ROW_BITS = 32;

    // Default lane count for the top level.
    localparam int MAX_ROW_PIXELS_DEF = 32;

    // Rows a blit may span; taller blits are saturated to this.
    localparam int MAX_ROWS = 64;

    localparam int COORD_W  = 13;
    localparam int ROW_W    = 6;
    localparam int BW_W     = 6;
    localparam int BH_W     = 7;
    localparam int STRIDE_W = 16;
    localparam int BPP_W    = 3;
    localparam int WORD_W   = 32;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LINE_STRIDE  = 3'd0,
        REG_BYTES_PER_PX = 3'd1,
        REG_CLIP_RIGHT   = 3'd2,
        REG_CLIP_BOTTOM  = 3'd3,
        REG_BASE_OFFSET  = 3'd4,
        REG_WRITE_ENABLE = 3'd5
    } cfg_reg_t;

    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = '0;
    localparam logic [BPP_W-1:0]    BPP_RST         = 3'd4;
    localparam logic [COORD_W-1:0]  CLIP_RST        = 13'd8191;
    localparam logic [WORD_W-1:0]   BASE_OFFSET_RST = '0;

    // Clip and draw-control settings seen by the row setup logic.
    typedef struct packed {
        logic [COORD_W-1:0] clip_right;
        logic [COORD_W-1:0] clip_bottom;
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic               write_enable;
    } mceb_clip_cfg_t;

endpackage

[rtl/mceb_row_clip.sv]
module mceb_row_clip
    import mceb_pkg::*;
#(
    parameter int LANES = ROW_BITS
)
(
    input  logic [COORD_W-1:0]  origin_x,
    input  logic [COORD_W-1:0]  origin_y,
    input  logic [ROW_W-1:0]    row_index,
    input  logic [BW_W-1:0]     blit_width,
    input  logic [BH_W-1:0]     blit_height,
    input  logic [ROW_BITS-1:0] pattern_row,
    input  logic [ROW_BITS-1:0] mask_row,
    input  logic                use_mask,
    input  mceb_clip_cfg_t      cfg,
    output logic [LANES-1:0]    lane_mask,
    output logic [LANES-1:0]    pattern_lanes
);

    localparam logic [BW_W:0] LANES_W = (BW_W+1)'(LANES);
    localparam logic [8:0]    ROWS_W  = 9'(MAX_ROWS);

    logic [BW_W:0]      w_sat;
    logic [8:0]         h_sat;
    logic [COORD_W:0]   x_end;
    logic [COORD_W:0]   y_end;
    logic [COORD_W:0]   w_eff;
    logic [COORD_W:0]   h_eff;
    logic               x_over;
    logic               y_over;
    logic               x_kill;
    logic               y_kill;
    logic               row_kill;
    logic               bpp_ok;
    logic               live;

    // Saturate the size to the lanes and the row limit.
    assign w_sat = ({1'b0, blit_width} > LANES_W) ? LANES_W : {1'b0, blit_width};
    assign h_sat = ({2'b0, blit_height} > ROWS_W) ? ROWS_W : {2'b0, blit_height};

    assign x_end  = {1'b0, origin_x} + (COORD_W+1)'(w_sat);
    assign y_end  = {1'b0, origin_y} + (COORD_W+1)'(h_sat);
    assign x_over = x_end > {1'b0, cfg.clip_right};
    assign y_over = y_end > {1'b0, cfg.clip_bottom};
    assign x_kill = x_over && (origin_x >= cfg.clip_right);
    assign y_kill = y_over && (origin_y >= cfg.clip_bottom);

    // Cut the size at the draw area edge.
    assign w_eff = x_over ? {1'b0, cfg.clip_right - origin_x} : (COORD_W+1)'(w_sat);
    assign h_eff = y_over ? {1'b0, cfg.clip_bottom - origin_y} : (COORD_W+1)'(h_sat);

    assign row_kill = (COORD_W+1)'(row_index) >= h_eff;
    assign bpp_ok   = cfg.bytes_per_pixel inside {[3'd1:3'd4]};
    assign live     = cfg.write_enable && bpp_ok && !x_kill && !y_kill && !row_kill;

    // Reverse into lane order: lane c is pixel c.
    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            lane_mask[c] = live && ((COORD_W+1)'(c) < w_eff)
                           && (!use_mask || mask_row[ROW_BITS-1-c]);
            pattern_lanes[c] = pattern_row[ROW_BITS-1-c];
        end
    end

endmodule

[rtl/mono_color_expand_blit.sv]
// Monochrome color-expansion blit. Each input item is one row of a 1-bit
// glyph or cursor bitmap (pixel 0 in bit 31) together with the blit origin,
// size, row number and the already resolved foreground and background
// values. The row is clipped to the draw area's right and bottom edges and
// expanded into one output item per visible pixel whose mask bit is set
// (every visible pixel when use_mask is low), from left to right, with last
// high on the final write of the row. Each output item carries a framebuffer
// byte offset, the pixel value trimmed to byte_count bytes, and byte_count
// itself (3 means bytes 23:16, 15:8, 7:0 at successive addresses). Rate:
// one write per cycle, set by the single output register, while out_ready
// does not stall it. The next row is taken in the same cycle the final write
// of the current row moves into the output register, so back-to-back rows
// stream without a gap. An accepted row is held in the row register, from
// which its first write moves into the output register. Configuration is
// written through cfg_wen/cfg_index/cfg_data and must only change while no
// row is in flight; writes to unknown indexes are ignored.
module mono_color_expand_blit
    import mceb_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port
    input  logic                 cfg_wen,
    input  logic [2:0]           cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    // Row input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [COORD_W-1:0]   origin_x,
    input  logic [COORD_W-1:0]   origin_y,
    input  logic [ROW_W-1:0]     row_index,
    input  logic [BW_W-1:0]      blit_width,
    input  logic [BH_W-1:0]      blit_height,
    input  logic [ROW_BITS-1:0]  pattern_row,
    input  logic [ROW_BITS-1:0]  mask_row,
    input  logic                 use_mask,
    input  logic [WORD_W-1:0]    fg_pixel,
    input  logic [WORD_W-1:0]    bg_pixel,

    // Pixel write output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    byte_offset,
    output logic [WORD_W-1:0]    pixel_data,
    output logic [BPP_W-1:0]     byte_count,
    output logic                 last
);

    // Lanes: the row is never wider than the bits an item carries.
    localparam int LANES  = (MAX_ROW_PIXELS < ROW_BITS) ? MAX_ROW_PIXELS : ROW_BITS;
    localparam int LIDX_W = $clog2(LANES);
    localparam int XS_W   = COORD_W + 3;

    // Keep the low n bytes of a pixel value for n of one to three, clear the rest; any other n keeps all four.
    function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] v,
                                                     input logic [BPP_W-1:0]  n);
        logic [WORD_W-1:0] r;
        begin
            case (n)
                3'd1:    r = {24'b0, v[7:0]};
                3'd2:    r = {16'b0, v[15:0]};
                3'd3:    r = {8'b0, v[23:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STRIDE_W-1:0] line_stride_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [COORD_W-1:0]  clip_right_reg;
    logic [COORD_W-1:0]  clip_bottom_reg;
    logic [WORD_W-1:0]   base_offset_reg;
    logic                write_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_stride_reg  <= LINE_STRIDE_RST;
            bpp_reg          <= BPP_RST;
            clip_right_reg   <= CLIP_RST;
            clip_bottom_reg  <= CLIP_RST;
            base_offset_reg  <= BASE_OFFSET_RST;
            write_enable_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_LINE_STRIDE:  line_stride_reg  <= cfg_data[STRIDE_W-1:0];
                REG_BYTES_PER_PX: bpp_reg          <= cfg_data[BPP_W-1:0];
                REG_CLIP_RIGHT:   clip_right_reg   <= cfg_data[COORD_W-1:0];
                REG_CLIP_BOTTOM:  clip_bottom_reg  <= cfg_data[COORD_W-1:0];
                REG_BASE_OFFSET:  base_offset_reg  <= cfg_data;
                REG_WRITE_ENABLE: write_enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row setup: clip and build the per-lane write mask at acceptance
    // ------------------------------------------------------------------
    mceb_clip_cfg_t   clip_cfg;
    logic [LANES-1:0] lane_mask;
    logic [LANES-1:0] pattern_lanes;

    assign clip_cfg.clip_right      = clip_right_reg;
    assign clip_cfg.clip_bottom     = clip_bottom_reg;
    assign clip_cfg.bytes_per_pixel = bpp_reg;
    assign clip_cfg.write_enable    = write_enable_reg;

    mceb_row_clip #(
        .LANES (LANES)
    ) u_row_clip (
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .row_index     (row_index),
        .blit_width    (blit_width),
        .blit_height   (blit_height),
        .pattern_row   (pattern_row),
        .mask_row      (mask_row),
        .use_mask      (use_mask),
        .cfg           (clip_cfg),
        .lane_mask     (lane_mask),
        .pattern_lanes (pattern_lanes)
    );

    // Start of this row in the framebuffer: (oy + row) * stride + base.
    logic [COORD_W:0]  line_y;
    logic [WORD_W-1:0] line_prod;
    logic [WORD_W-1:0] line_next;

    assign line_y    = {1'b0, origin_y} + (COORD_W+1)'(row_index);
    assign line_prod = WORD_W'(line_y) * WORD_W'(line_stride_reg);
    assign line_next = line_prod + base_offset_reg;

    // ------------------------------------------------------------------
    // Row register: pending pixels of the row being expanded
    // ------------------------------------------------------------------
    logic [LANES-1:0]   pend_reg;
    logic [LANES-1:0]   pend_next;
    logic [LANES-1:0]   pat_reg;
    logic [COORD_W-1:0] ox_reg;
    logic [WORD_W-1:0]  line_reg;
    logic [WORD_W-1:0]  fg_reg;
    logic [WORD_W-1:0]  bg_reg;

    logic [LANES-1:0]   pick;
    logic [LANES-1:0]   rest;
    logic [LIDX_W-1:0]  pick_idx;
    logic               busy;
    logic               emit;
    logic               row_done;
    logic               in_fire;
    logic               out_valid_reg;

    // Leftmost pending pixel is the lowest set lane.
    assign pick     = pend_reg & (~pend_reg + 1'b1);
    assign rest     = pend_reg & ~pick;
    assign busy     = |pend_reg;
    assign row_done = ~|rest;
    assign emit     = busy && (!out_valid_reg || out_ready);
    assign in_ready = !busy || (emit && row_done);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        pick_idx = '0;
        for (int c = 0; c < LANES; c++)
        begin
            if (pick[c])
            begin
                pick_idx = pick_idx | LIDX_W'(c);
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire)
        begin
            pend_next = lane_mask;
        end
        else if (emit)
        begin
            pend_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Row payload: hold until the next row is taken.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pat_reg  <= pattern_lanes;
            ox_reg   <= origin_x;
            line_reg <= line_next;
            fg_reg   <= keep_bytes(fg_pixel, bpp_reg);
            bg_reg   <= keep_bytes(bg_pixel, bpp_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register: while out_ready does not stall it, one pixel write per cycle
    // ------------------------------------------------------------------
    logic [COORD_W:0]   col_x;
    logic [XS_W-1:0]    col_bytes;
    logic [WORD_W-1:0]  offset_next;
    logic [WORD_W-1:0]  data_next;

    logic [WORD_W-1:0]  offset_reg;
    logic [WORD_W-1:0]  data_reg;
    logic [BPP_W-1:0]   count_reg;
    logic               last_reg;

    assign col_x = {1'b0, ox_reg} + (COORD_W+1)'(pick_idx);

    // Column times pixel size by shift and add for sizes one to four; any other size gives zero.
    always_comb
    begin
        case (bpp_reg)
            3'd1:    col_bytes = XS_W'(col_x);
            3'd2:    col_bytes = XS_W'({col_x, 1'b0});
            3'd3:    col_bytes = XS_W'({col_x, 1'b0}) + XS_W'(col_x);
            3'd4:    col_bytes = XS_W'({col_x, 2'b00});
            default: col_bytes = '0;
        endcase
    end

    assign offset_next = line_reg + WORD_W'(col_bytes);
    assign data_next   = pat_reg[pick_idx] ? fg_reg : bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Advance the output payload only when a new write moves in.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            offset_reg <= offset_next;
            data_reg   <= data_next;
            count_reg  <= bpp_reg;
            last_reg   <= row_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_offset = offset_reg;
    assign pixel_data  = data_reg;
    assign byte_count  = count_reg;
    assign last        = last_reg;

endmodule
